// ----- design/vse_pkg.sv -----
package vse_pkg;

  // Configuration register map, one register per 32-bit slot.
  typedef enum logic [1:0] {
    REG_SIZE_X    = 2'd0,
    REG_SIZE_Y    = 2'd1,
    REG_SIZE_Z    = 2'd2,
    REG_THRESHOLD = 2'd3
  } vse_reg_e;

  localparam int unsigned AddrWidth   = 4;
  localparam int unsigned DataWidth   = 32;
  localparam int unsigned SizeXYWidth = 7;
  localparam int unsigned SizeZWidth  = 10;
  localparam int unsigned ThrWidth    = 16;

  // Result index fields as they leave the block.
  localparam int unsigned ShellXWidth = 6;
  localparam int unsigned ShellYWidth = 6;
  localparam int unsigned ShellZWidth = 9;
  localparam int unsigned MaxZ        = 512;

  // One window column: 3 rows by 3 planes of occupancy bits, bit index
  // is plane_offset*3 + row_offset. The center of the cube is bit 4.
  localparam int unsigned ColWidth  = 9;
  localparam int unsigned CenterBit = 4;

  // Line buffer control, shared by both delay lines.
  typedef struct packed {
    logic advance;  // one word accepted: write and step the pointer
    logic restart;  // grid size changed: pointer back to slot zero
  } vse_lb_ctrl_t;

endpackage

// ----- design/voxel_shell_extract_unit.sv -----
// Voxel shell extractor. Voxel values stream in on the slave side in raster
// order, x fastest, then y, then z, one word per clock cycle at full rate. A
// voxel is occupied when its signed value is strictly above the threshold
// register. For every occupied voxel off the faces of the grid that has at
// least one empty voxel in its 3x3x3 neighborhood, one word with its x, y,
// z indices and its value leaves on the master side. That word is decided
// when the voxel one plane, one row and one voxel further arrives, so it
// trails its input by size_x*size_y + size_x + 1 words. It is registered in
// the main register, or in the skid register while the main one is full and
// not taken, and leaves from the main one. Internally two line buffers, one
// row deep and one plane deep (MAX_X*MAX_Y words of RAM), feed a row of two
// window cells that hold the last two 9-bit columns; no clearing pass is
// needed after reset. A two-entry output stage keeps the input side open
// while a result waits; the slave side stalls only while both entries are
// full. Writing a size register restarts the raster position at the origin
// of a new grid; sizes below 3 act as 3 and sizes above the limits act as
// the limits. Configure only while idle.

module voxel_shell_extract_unit #(
  parameter int unsigned MAX_X       = 64,
  parameter int unsigned MAX_Y       = 64,
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Slave side. tdata: voxel_value.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [((VALUE_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
  // Master side. tdata: shell_x, shell_y, shell_z, shell_value.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [((VALUE_WIDTH+28)/8)*8-1:0]   m_axis_tdata,
  // Configuration port.
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [vse_pkg::AddrWidth-1:0]       paddr,
  input  logic [vse_pkg::DataWidth-1:0]       pwdata,
  output logic [vse_pkg::DataWidth-1:0]       prdata,
  output logic                                pready
);

  localparam int unsigned VW      = VALUE_WIDTH;
  localparam int unsigned OUT_W   = ((VALUE_WIDTH + 28) / 8) * 8;
  localparam int unsigned PLANE_D = MAX_X * MAX_Y;
  localparam int unsigned CXW     = $clog2(MAX_X);
  localparam int unsigned CYW     = $clog2(MAX_Y);
  localparam int unsigned SXW     = $clog2(MAX_X + 1);
  localparam int unsigned SYW     = $clog2(MAX_Y + 1);
  localparam int unsigned PLW     = $clog2(PLANE_D + 1);
  localparam int unsigned CZW     = vse_pkg::ShellZWidth;
  localparam int unsigned SZW     = vse_pkg::SizeZWidth;
  localparam int unsigned XW      = (CXW > vse_pkg::ShellXWidth) ? CXW : vse_pkg::ShellXWidth;
  localparam int unsigned YW      = (CYW > vse_pkg::ShellYWidth) ? CYW : vse_pkg::ShellYWidth;
  localparam int unsigned CMPW    = (VW > vse_pkg::ThrWidth) ? VW : vse_pkg::ThrWidth;
  localparam int unsigned RB_W    = VW + 2;
  localparam int unsigned PB_W    = VW + 6;
  localparam int unsigned CW      = vse_pkg::ColWidth;

  // ---------------------------------------------------------------------
  // Configuration registers. The stored values are the raw written bits;
  // clamping to the legal range happens on the way into the datapath.
  // ---------------------------------------------------------------------
  logic [vse_pkg::SizeXYWidth-1:0] size_x_q, size_y_q;
  logic [SZW-1:0]                  size_z_q;
  logic [vse_pkg::ThrWidth-1:0]    thr_q;
  logic                            cfg_wr;
  logic                            size_wr;
  vse_pkg::vse_reg_e               cfg_reg;

  assign pready  = 1'b1;
  assign cfg_reg = vse_pkg::vse_reg_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign size_wr = cfg_wr && (cfg_reg == vse_pkg::REG_SIZE_X ||
                              cfg_reg == vse_pkg::REG_SIZE_Y ||
                              cfg_reg == vse_pkg::REG_SIZE_Z);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q <= vse_pkg::SizeXYWidth'(64);
      size_y_q <= vse_pkg::SizeXYWidth'(64);
      size_z_q <= SZW'(512);
      thr_q    <= '0;
    end else if (cfg_wr) begin
      case (cfg_reg)
        vse_pkg::REG_SIZE_X:    size_x_q <= pwdata[vse_pkg::SizeXYWidth-1:0];
        vse_pkg::REG_SIZE_Y:    size_y_q <= pwdata[vse_pkg::SizeXYWidth-1:0];
        vse_pkg::REG_SIZE_Z:    size_z_q <= pwdata[SZW-1:0];
        vse_pkg::REG_THRESHOLD: thr_q    <= pwdata[vse_pkg::ThrWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_reg)
      vse_pkg::REG_SIZE_X:    prdata = vse_pkg::DataWidth'(size_x_q);
      vse_pkg::REG_SIZE_Y:    prdata = vse_pkg::DataWidth'(size_y_q);
      vse_pkg::REG_SIZE_Z:    prdata = vse_pkg::DataWidth'(size_z_q);
      vse_pkg::REG_THRESHOLD: prdata = vse_pkg::DataWidth'(thr_q);
      default:                prdata = '0;
    endcase
  end

  // Effective grid sizes.
  logic [SXW-1:0] sx;
  logic [SYW-1:0] sy;
  logic [SZW-1:0] sz;
  logic [PLW-1:0] plane;

  always_comb begin
    if (size_x_q < 7'd3) begin
      sx = SXW'(3);
    end else if (32'(size_x_q) > MAX_X) begin
      sx = SXW'(MAX_X);
    end else begin
      sx = SXW'(size_x_q);
    end
    if (size_y_q < 7'd3) begin
      sy = SYW'(3);
    end else if (32'(size_y_q) > MAX_Y) begin
      sy = SYW'(MAX_Y);
    end else begin
      sy = SYW'(size_y_q);
    end
    if (size_z_q < SZW'(3)) begin
      sz = SZW'(3);
    end else if (32'(size_z_q) > vse_pkg::MaxZ) begin
      sz = SZW'(vse_pkg::MaxZ);
    end else begin
      sz = size_z_q;
    end
  end

  assign plane = PLW'(sx * sy);

  // ---------------------------------------------------------------------
  // Output stage: a main register and a skid register. The slave side is
  // only held off while the skid register is full.
  // ---------------------------------------------------------------------
  logic             main_vld_q, skid_vld_q;
  logic [OUT_W-1:0] main_q, skid_q;
  logic             in_acc, hit, pop;
  logic [OUT_W-1:0] res_word;

  assign s_axis_tready = !skid_vld_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign pop           = main_vld_q && m_axis_tready;
  assign m_axis_tvalid = main_vld_q;
  assign m_axis_tdata  = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (pop) begin
        skid_vld_q <= 1'b0;
      end
    end else if (in_acc && hit) begin
      if (main_vld_q && !pop) begin
        skid_vld_q <= 1'b1;
      end else begin
        main_vld_q <= 1'b1;
      end
    end else if (pop) begin
      main_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (pop) begin
        main_q <= skid_q;
      end
    end else if (in_acc && hit) begin
      if (main_vld_q && !pop) begin
        skid_q <= res_word;
      end else begin
        main_q <= res_word;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Raster position of the incoming word.
  // ---------------------------------------------------------------------
  logic [CXW-1:0] col_q;
  logic [CYW-1:0] row_q;
  logic [CZW-1:0] pln_q;
  logic           col_end, row_end, pln_end;

  assign col_end = (SXW'(col_q) + SXW'(1)) >= sx;
  assign row_end = (SYW'(row_q) + SYW'(1)) >= sy;
  assign pln_end = (SZW'(pln_q) + SZW'(1)) >= sz;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      pln_q <= '0;
    end else if (size_wr) begin
      col_q <= '0;
      row_q <= '0;
      pln_q <= '0;
    end else if (in_acc) begin
      if (col_end) begin
        col_q <= '0;
        if (row_end) begin
          row_q <= '0;
          pln_q <= pln_end ? '0 : pln_q + CZW'(1);
        end else begin
          row_q <= row_q + CYW'(1);
        end
      end else begin
        col_q <= col_q + CXW'(1);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Occupancy of the incoming word and the two line buffers.
  // ---------------------------------------------------------------------
  logic [VW-1:0]   vox;
  logic            occ_now;
  logic [RB_W-1:0] row_rd;
  logic [PB_W-1:0] pln_rd;
  logic [2:0]      col_cur;
  logic [CW-1:0]   col_now;
  vse_pkg::vse_lb_ctrl_t lb_ctrl;

  assign vox     = s_axis_tdata[VW-1:0];
  assign occ_now = $signed(CMPW'($signed(vox))) > $signed(CMPW'($signed(thr_q)));

  assign lb_ctrl.advance = in_acc;
  assign lb_ctrl.restart = size_wr;

  // The row buffer holds {value, occupancy one row back, occupancy now}
  // and returns them one row later, which gives the two rows above.
  vse_delay_line #(
    .WIDTH (RB_W),
    .DEPTH (MAX_X)
  ) u_row_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (lb_ctrl),
    .len_i   (sx),
    .wdata_i ({vox, row_rd[0], occ_now}),
    .rdata_o (row_rd)
  );

  assign col_cur = {row_rd[1], row_rd[0], occ_now};

  // The plane buffer carries the current plane's column, the value one row
  // back and the column one plane back, so one read yields the two planes
  // behind plus the value that the center voxel needs.
  vse_delay_line #(
    .WIDTH (PB_W),
    .DEPTH (PLANE_D)
  ) u_plane_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (lb_ctrl),
    .len_i   (plane),
    .wdata_i ({pln_rd[2:0], row_rd[RB_W-1:2], col_cur}),
    .rdata_o (pln_rd)
  );

  assign col_now = {pln_rd[PB_W-1:VW+3], pln_rd[2:0], col_cur};

  // ---------------------------------------------------------------------
  // Window cells: each holds one column and hands it on to the next. Cell
  // zero holds the center column and the center value.
  // ---------------------------------------------------------------------
  logic [CW-1:0] c0_col, c1_col;
  logic [VW-1:0] c0_val, c1_val;
  logic          c0_full, c1_full;

  vse_cell #(
    .VAL_W (VW)
  ) u_cell0 (
    .clk_i  (clk_i),
    .en_i   (in_acc),
    .col_i  (col_now),
    .val_i  (pln_rd[VW+2:3]),
    .col_o  (c0_col),
    .val_o  (c0_val),
    .full_o (c0_full)
  );

  vse_cell #(
    .VAL_W (VW)
  ) u_cell1 (
    .clk_i  (clk_i),
    .en_i   (in_acc),
    .col_i  (c0_col),
    .val_i  (c0_val),
    .col_o  (c1_col),
    .val_o  (c1_val),
    .full_o (c1_full)
  );

  // The second cell's value is the end of the chain; it only joins the
  // check that the whole cube is taken.
  logic pos_ok, all_occ;
  logic [XW-1:0] x_ext;
  logic [YW-1:0] y_ext;
  logic [CZW-1:0] z_idx;

  assign pos_ok  = (col_q >= CXW'(2)) && (row_q >= CYW'(2)) && (pln_q >= CZW'(2));
  assign all_occ = (&col_now) && c0_full && (c1_full || (c1_val != c1_val));
  assign hit     = pos_ok && c0_col[vse_pkg::CenterBit] && !all_occ;

  assign x_ext = XW'(col_q) - XW'(1);
  assign y_ext = YW'(row_q) - YW'(1);
  assign z_idx = pln_q - CZW'(1);

  assign res_word = OUT_W'({c0_val, z_idx,
                            y_ext[vse_pkg::ShellYWidth-1:0],
                            x_ext[vse_pkg::ShellXWidth-1:0]});

endmodule

// ----- design/vse_delay_line.sv -----
module vse_delay_line #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  vse_pkg::vse_lb_ctrl_t        ctrl_i,
  input  logic [$clog2(DEPTH+1)-1:0]   len_i,
  input  logic [WIDTH-1:0]             wdata_i,
  output logic [WIDTH-1:0]             rdata_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned LW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    ptr_q, ptr_d;
  logic [WIDTH-1:0] rdata_q;

  // The pointer circles over len_i slots, so a slot is read back exactly
  // len_i words after it was written.
  always_comb begin
    ptr_d = ptr_q;
    if (ctrl_i.restart) begin
      ptr_d = '0;
    end else if (ctrl_i.advance) begin
      if (LW'(ptr_q) == len_i - LW'(1)) begin
        ptr_d = '0;
      end else begin
        ptr_d = ptr_q + PW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
    end else begin
      ptr_q <= ptr_d;
    end
  end

  // The read runs one slot ahead, so the oldest word is ready when the
  // next word arrives.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.advance) begin
      mem[ptr_q] <= wdata_i;
    end
    rdata_q <= mem[ptr_d];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/vse_cell.sv -----
module vse_cell #(
  parameter int unsigned VAL_W = 16
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [vse_pkg::ColWidth-1:0]  col_i,
  input  logic [VAL_W-1:0]              val_i,
  output logic [vse_pkg::ColWidth-1:0]  col_o,
  output logic [VAL_W-1:0]              val_o,
  output logic                          full_o
);

  logic [vse_pkg::ColWidth-1:0] col_q;
  logic [VAL_W-1:0]             val_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      col_q <= col_i;
      val_q <= val_i;
    end
  end

  assign col_o  = col_q;
  assign val_o  = val_q;
  assign full_o = &col_q;

endmodule

// ----- design/vse_checker.sv -----
module vse_checker #(
  parameter int unsigned OUT_W = 40
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata
);

  // A result word waiting on the master side stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result word dropped while stalled");

  // Its payload does not change while it waits.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // The input side is only held off while a result is pending.
  a_ready_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input held off with no result pending");

  // A new result only appears right after an input word was taken.
  a_result_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready))
    else $error("result word without an accepted input word");

endmodule

bind voxel_shell_extract_unit vse_checker #(
  .OUT_W (OUT_W)
) u_vse_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ----- verif/tb.sv -----
`timescale 1ns / 100ps

// Stream-level check of the voxel shell extractor. Voxel words are queued in
// phases by the stimulus block below. Each phase sets up a grid over the
// register port while the block is idle, then streams voxels into it. The
// driver predicts the shell word for every voxel the block accepts. The
// monitor compares each word leaving the master side with the oldest
// prediction.
module tb;

  localparam int unsigned MaxX      = 64;
  localparam int unsigned MaxY      = 64;
  localparam int unsigned OccDepth  = 2 * MaxX * MaxY + 2 * MaxX + 3;
  localparam int unsigned ValDepth  = MaxX * MaxY + MaxX + 2;
  // Slack for the window pipeline and the output stage.
  localparam int unsigned SettleCycles = 32;
  localparam int unsigned VoxelTarget  = 1450;
  localparam longint      RunLimitNs   = 64'd1_600_000;

  typedef struct {
    logic [vse_pkg::ShellXWidth-1:0] x;
    logic [vse_pkg::ShellYWidth-1:0] y;
    logic [vse_pkg::ShellZWidth-1:0] z;
    logic [15:0]                     value;
  } shell_t;

  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [15:0]                   s_axis_tdata  = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [39:0]                   m_axis_tdata;
  logic                          psel          = 1'b0;
  logic                          penable       = 1'b0;
  logic                          pwrite        = 1'b0;
  logic [vse_pkg::AddrWidth-1:0] paddr         = '0;
  logic [vse_pkg::DataWidth-1:0] pwdata        = '0;
  logic [vse_pkg::DataWidth-1:0] prdata;
  logic                          pready;

  voxel_shell_extract_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Shadow copy of the block: registers, raster position and the two delay
  // lines. The delay lines are circular; only the distance back from the
  // write pointer matters, so the pointers need not match the hardware.
  logic [vse_pkg::SizeXYWidth-1:0] grid_sx  = 7'd64;
  logic [vse_pkg::SizeXYWidth-1:0] grid_sy  = 7'd64;
  logic [vse_pkg::SizeZWidth-1:0]  grid_sz  = 10'd512;
  logic signed [15:0]              grid_thr = '0;
  bit                              occ_line [OccDepth];
  logic signed [15:0]              val_line [ValDepth];
  int unsigned                     occ_ptr  = 0;
  int unsigned                     val_ptr  = 0;
  int unsigned                     col      = 0;
  int unsigned                     row      = 0;
  int unsigned                     pln      = 0;

  logic [15:0]  voxel_backlog [$];
  shell_t       shell_expected [$];
  int unsigned  voxels_queued   = 0;
  int unsigned  voxels_accepted = 0;
  int unsigned  mismatches      = 0;
  int unsigned  send_idle_pct;
  int unsigned  recv_idle_pct;

  // Idling schedule: the sender idles lightly and the receiver heavily for
  // the first third of the run, then the other way round, then neither.
  always_comb begin
    if (voxels_accepted < VoxelTarget / 3) begin
      send_idle_pct = 27;
      recv_idle_pct = 72;
    end else if (voxels_accepted < 2 * VoxelTarget / 3) begin
      send_idle_pct = 72;
      recv_idle_pct = 27;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  end

  function automatic int unsigned clamp_size(input int unsigned v, input int unsigned hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return v;
  endfunction

  // One accepted voxel: store its occupancy and value, then decide the
  // voxel one plane, one row and one column back, which is the center of
  // the 3x3x3 cube that ends at this voxel.
  task automatic take_voxel(input logic signed [15:0] v);
    int unsigned sx, sy, sz, plane, lag, reach;
    int unsigned a, b, c;
    bit          hole;
    shell_t      s;
    sx    = clamp_size(grid_sx, MaxX);
    sy    = clamp_size(grid_sy, MaxY);
    sz    = clamp_size(grid_sz, vse_pkg::MaxZ);
    plane = sx * sy;
    occ_line[occ_ptr] = (v > grid_thr);
    val_line[val_ptr] = v;
    if (col >= 2 && row >= 2 && pln >= 2) begin
      lag  = plane + sx + 1;
      hole = 1'b0;
      for (c = 0; c < 3; c++) begin
        for (b = 0; b < 3; b++) begin
          for (a = 0; a < 3; a++) begin
            reach = c * plane + b * sx + a;
            if (!occ_line[(occ_ptr + OccDepth - reach) % OccDepth]) hole = 1'b1;
          end
        end
      end
      if (occ_line[(occ_ptr + OccDepth - lag) % OccDepth] && hole) begin
        s.x     = vse_pkg::ShellXWidth'(col - 1);
        s.y     = vse_pkg::ShellYWidth'(row - 1);
        s.z     = vse_pkg::ShellZWidth'(pln - 1);
        s.value = val_line[(val_ptr + ValDepth - lag) % ValDepth];
        shell_expected.push_back(s);
      end
    end
    occ_ptr = (occ_ptr + 1) % OccDepth;
    val_ptr = (val_ptr + 1) % ValDepth;
    col++;
    if (col >= sx) begin
      col = 0;
      row++;
      if (row >= sy) begin
        row = 0;
        pln++;
        if (pln >= sz) pln = 0;
      end
    end
    if (row >= sy) row = 0;
    if (pln >= sz) pln = 0;
  endtask

  // Driver: a word stays on the bus until it is taken; new words are
  // offered only when the bus is free, with random idle cycles in between.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        take_voxel(s_axis_tdata);
        voxels_accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (voxel_backlog.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          s_axis_tdata  <= voxel_backlog.pop_front();
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver stalls.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Monitor. The master word carries shell_x, shell_y, shell_z and
  // shell_value from bit 0 up.
  always @(posedge clk_i) begin
    shell_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.x     = m_axis_tdata[5:0];
      got.y     = m_axis_tdata[11:6];
      got.z     = m_axis_tdata[20:12];
      got.value = m_axis_tdata[36:21];
      if (shell_expected.size() == 0) begin
        mismatches++;
        $display("%0t: shell word with nothing expected: expected none, actual x=%0d y=%0d z=%0d value=%h",
                 $time, got.x, got.y, got.z, got.value);
      end else begin
        want = shell_expected.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
            got.value !== want.value) begin
          mismatches++;
          $display("%0t: shell word: expected x=%0d y=%0d z=%0d value=%h, actual x=%0d y=%0d z=%0d value=%h",
                   $time, want.x, want.y, want.z, want.value,
                   got.x, got.y, got.z, got.value);
        end
      end
    end
  end

  // Register write: setup cycle, then access cycle. The shadow copy takes
  // the new value at the edge where the block does.
  task automatic reg_write(input vse_pkg::vse_reg_e idx, input logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      vse_pkg::REG_SIZE_X:    grid_sx  = data[vse_pkg::SizeXYWidth-1:0];
      vse_pkg::REG_SIZE_Y:    grid_sy  = data[vse_pkg::SizeXYWidth-1:0];
      vse_pkg::REG_SIZE_Z:    grid_sz  = data[vse_pkg::SizeZWidth-1:0];
      vse_pkg::REG_THRESHOLD: grid_thr = data[vse_pkg::ThrWidth-1:0];
      default: ;
    endcase
    // A size write restarts the raster at the origin of a new grid.
    if (idx != vse_pkg::REG_THRESHOLD) begin
      col = 0;
      row = 0;
      pln = 0;
    end
  endtask

  // Wait until every queued voxel is taken and every shell word is out,
  // then give the window pipeline time to drain.
  task automatic wait_idle();
    while (voxel_backlog.size() != 0 || s_axis_tvalid || shell_expected.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic logic [15:0] make_value(input bit occupied);
    int t, r;
    t = grid_thr;
    if (occupied && t < 32767) begin
      r = $urandom_range(0, 32766 - t);
      if ($urandom_range(0, 1)) r = r % 4;
      return 16'(t + 1 + r);
    end
    r = $urandom_range(0, t + 32768);
    if ($urandom_range(0, 1)) r = r % 4;
    return 16'(t - r);
  endfunction

  function automatic logic [15:0] pick_threshold(input int phase);
    if (phase == 0) return 16'h8000;
    if (phase == 2) return 16'h7FFF;
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      default: return 16'($urandom_range(0, 16'h2000)) - 16'h1000;
    endcase
  endfunction

  // Dense phases make solid blobs where most interior voxels have no empty
  // neighbor; sparse ones leave isolated occupied voxels. A tenth of the
  // words are raw noise.
  task automatic queue_voxels(input int n, input int density);
    int i;
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) voxel_backlog.push_back(16'($urandom));
      else voxel_backlog.push_back(make_value($urandom_range(0, 99) < density));
      voxels_queued++;
    end
  endtask

  // One grid setup followed by n voxels. Sometimes the threshold changes
  // halfway through the voxels; earlier occupancy bits keep their old sense.
  task automatic run_grid(input int unsigned wx, input int unsigned wy,
                          input int unsigned wz, input int n, input int phase);
    int density, first;
    wait_idle();
    reg_write(vse_pkg::REG_SIZE_X, {$urandom} & 32'hFFFF_FF80 | wx);
    reg_write(vse_pkg::REG_SIZE_Y, {$urandom} & 32'hFFFF_FF80 | wy);
    reg_write(vse_pkg::REG_SIZE_Z, {$urandom} & 32'hFFFF_FC00 | wz);
    reg_write(vse_pkg::REG_THRESHOLD, {16'($urandom), pick_threshold(phase)});
    case ($urandom_range(0, 4))
      0:       density = 100;
      1:       density = 90;
      2:       density = 30;
      3:       density = 0;
      default: density = 60;
    endcase
    first = ($urandom_range(0, 2) == 0) ? n / 2 : n;
    queue_voxels(first, density);
    if (first < n) begin
      wait_idle();
      reg_write(vse_pkg::REG_THRESHOLD, {16'($urandom), pick_threshold(phase + 10)});
      queue_voxels(n - first, density);
    end
  endtask

  initial begin
    int phase, sx, sy, sz, grid;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Two extreme values on the grid left by reset.
    voxel_backlog.push_back(16'h8000);
    voxel_backlog.push_back(16'h7FFF);
    wait_idle();

    // Sizes below 3 act as 3, so this is a 3x3x3 grid with one interior
    // voxel. The first voxel sits exactly on the threshold and so is
    // empty; the rest are just above it. Halfway the threshold rises by
    // one: the stored bits keep their sense and the later voxels are
    // raised to stay occupied, so the center comes out as a shell voxel.
    reg_write(vse_pkg::REG_SIZE_X, 32'd0);
    reg_write(vse_pkg::REG_SIZE_Y, 32'd1);
    reg_write(vse_pkg::REG_SIZE_Z, 32'd2);
    reg_write(vse_pkg::REG_THRESHOLD, 32'h0000_0100);
    voxel_backlog.push_back(16'h0100);
    repeat (12) voxel_backlog.push_back(16'h0101);
    wait_idle();
    reg_write(vse_pkg::REG_THRESHOLD, 32'h0000_0101);
    repeat (14) voxel_backlog.push_back(16'h0102);
    voxels_queued = 29;

    // Random part. A few phases cover the largest sizes (x at its limit
    // through an oversized write, y at its limit, z at its limit through
    // an oversized write); the rest use small grids, often running past
    // the end of a grid into the next one.
    phase = 0;
    while (voxels_queued < VoxelTarget || phase < 6) begin
      case (phase)
        1: run_grid(127, 3, 3, 64 * 9, phase);
        3: run_grid(3, 64, 3, 64 * 9, phase);
        4: run_grid(3, 3, 1023, 90, phase);
        5: run_grid(3, 3, 512, 40, phase);
        default: begin
          sx   = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
          sy   = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
          sz   = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 5);
          grid = clamp_size(sx, MaxX) * clamp_size(sy, MaxY) *
                 clamp_size(sz, vse_pkg::MaxZ);
          run_grid(sx, sy, sz, grid * $urandom_range(1, 2) + $urandom_range(0, grid - 1),
                   phase);
        end
      endcase
      phase++;
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #(RunLimitNs);
    $display("Mismatches found");
    $finish;
  end

endmodule
